FILE: rtl/bdl_pkg.sv
package bdl_pkg;

	localparam int NUM_GROUPS_DEF = 3;
	localparam int Q_DEPTH_DEF    = 2;

	localparam int GL_W   = 8;
	localparam int BG_W   = 28;
	localparam int ADDR_W = 5;

	localparam logic [2:0] MODE_NONE   = 3'd0;
	localparam logic [2:0] MODE_ALL    = 3'd1;
	localparam logic [2:0] MODE_ORDER  = 3'd2;
	localparam logic [2:0] MODE_RANDOM = 3'd3;
	localparam logic [2:0] MODE_STACK  = 3'd4;

	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_SENSITIVITY = 3'd1;
	localparam logic [2:0] REG_SMOOTHING   = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE    = 3'd3;
	localparam logic [2:0] REG_PULSE       = 3'd4;

	localparam logic [11:0] SENSITIVITY_RST = 12'd384;
	localparam logic [15:0] SMOOTHING_RST   = 16'd64881;
	localparam logic [15:0] DEBOUNCE_RST    = 16'd250;
	localparam logic [15:0] PULSE_RST       = 16'd150;

	localparam logic [11:0] MIDSCALE = 12'd2048;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] sensitivity;
		logic [15:0] smoothing;
		logic [15:0] debounce_ms;
		logic [15:0] pulse_ms;
	} bdl_cfg_t;

	typedef struct packed {
		logic [11:0] level;
		logic [31:0] time_ms;
	} bdl_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_CMP,
		ST_COMMIT
	} bdl_state_t;

	function automatic logic [GL_W-1:0] group_bit(input logic [2:0] g);
		return GL_W'(1) << g;
	endfunction

	// Galois form, right shift
	function automatic logic [15:0] lfsr_step(input logic [15:0] v);
		logic [15:0] r;
		r = v >> 1;
		if (v[0]) begin
			r = r ^ LFSR_TAPS;
		end
		return r;
	endfunction

endpackage

FILE: rtl/bdl_regs.sv
module bdl_regs
	import bdl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output bdl_cfg_t          cfg
);

	bdl_cfg_t    cfg_q;
	logic [2:0]  idx;

	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_NONE;
			cfg_q.sensitivity <= SENSITIVITY_RST;
			cfg_q.smoothing   <= SMOOTHING_RST;
			cfg_q.debounce_ms <= DEBOUNCE_RST;
			cfg_q.pulse_ms    <= PULSE_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_MODE:        cfg_q.mode        <= pwdata[2:0];
				REG_SENSITIVITY: cfg_q.sensitivity <= pwdata[11:0];
				REG_SMOOTHING:   cfg_q.smoothing   <= pwdata[15:0];
				REG_DEBOUNCE:    cfg_q.debounce_ms <= pwdata[15:0];
				REG_PULSE:       cfg_q.pulse_ms    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:        prdata = {29'b0, cfg_q.mode};
			REG_SENSITIVITY: prdata = {20'b0, cfg_q.sensitivity};
			REG_SMOOTHING:   prdata = {16'b0, cfg_q.smoothing};
			REG_DEBOUNCE:    prdata = {16'b0, cfg_q.debounce_ms};
			REG_PULSE:       prdata = {16'b0, cfg_q.pulse_ms};
			default:         prdata = 32'b0;
		endcase
	end

endmodule

FILE: rtl/bdl_front.sv
module bdl_front
	import bdl_pkg::*;
(
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        q_full,
	output logic        q_push,
	output bdl_item_t   q_item
);

	logic [11:0] sample;

	assign sample   = s_tdata[11:0];
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	// distance from midscale, 0..2048
	always_comb begin
		if (sample >= MIDSCALE) begin
			q_item.level = sample - MIDSCALE;
		end else begin
			q_item.level = MIDSCALE - sample;
		end
		q_item.time_ms = s_tdata[43:12];
	end

endmodule

FILE: rtl/bdl_fifo.sv
module bdl_fifo
	import bdl_pkg::*;
#(
	parameter int DEPTH = Q_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bdl_item_t wr_item,
	input  logic      pop,
	output bdl_item_t rd_item,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bdl_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/bdl_back.sv
module bdl_back
	import bdl_pkg::*;
#(
	parameter int NUM_GROUPS = NUM_GROUPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  bdl_cfg_t   cfg,
	input  logic       q_empty,
	input  bdl_item_t  q_item,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata
);

	localparam int OC_W = (NUM_GROUPS > 2) ? $clog2(NUM_GROUPS) : 1;
	localparam int SC_W = $clog2(2 * NUM_GROUPS);
	localparam logic [GL_W-1:0] ALL_MASK = GL_W'((1 << NUM_GROUPS) - 1);
	// ceil(2^32 / NUM_GROUPS): exact quotient for any 16-bit value
	localparam logic [31:0] LFSR_RECIP =
		32'((64'h1_0000_0000 + 64'(NUM_GROUPS) - 64'd1) / 64'(NUM_GROUPS));

	bdl_state_t state_q, state_d;
	logic       commit;

	// per-item pipeline
	bdl_item_t   item_s1;
	logic [43:0] prod_bg_s2;
	logic [28:0] prod_lv_s2;
	logic [47:0] lfsr_prod_s2;
	logic [BG_W-1:0] bg_new_s3;
	logic [2:0]  lfsr_rem_s3;
	logic [39:0] thr_s4;

	// block state
	logic [BG_W-1:0] bg_q, bg_d;
	logic            primed_q, primed_d;
	logic            prev_q, prev_d;
	logic            pulse_active_q, pulse_active_d;
	logic [31:0]     pulse_start_q, pulse_start_d;
	logic [31:0]     last_beat_q, last_beat_d;
	logic [OC_W-1:0] order_q, order_d;
	logic [SC_W-1:0] stack_q, stack_d;
	logic [GL_W-1:0] lights_q, lights_d;
	logic [15:0]     lfsr_q, lfsr_d;

	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;

	logic [15:0] lfsr_next;
	logic [16:0] new_weight;
	logic [44:0] bg_sum;
	logic        detected;
	logic        trig;
	logic        start_pulse;
	logic        upd_d;
	logic        beat_d;
	logic [31:0] since_beat;
	logic [31:0] since_pulse;

	assign lfsr_next  = lfsr_step(lfsr_q);
	assign new_weight = 17'h1_0000 - {1'b0, cfg.smoothing};
	assign bg_sum     = {1'b0, prod_bg_s2} + {prod_lv_s2, 16'b0};
	assign since_beat  = item_s1.time_ms - last_beat_q;
	assign since_pulse = item_s1.time_ms - pulse_start_q;
	assign detected    = {4'b0, item_s1.level, 24'b0} > thr_s4;
	assign trig = detected && !prev_q && (since_beat > {16'b0, cfg.debounce_ms});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_CMP;
			ST_CMP: state_d = ST_COMMIT;
			ST_COMMIT: begin
				// hold until the output register frees up
				if (!m_tvalid_q || m_tready) begin
					commit = 1'b1;
					if (!q_empty) begin
						q_pop   = 1'b1;
						state_d = ST_MUL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_item;
		end
		if (state_q == ST_MUL) begin
			prod_bg_s2   <= 44'(bg_q) * 44'(cfg.smoothing);
			prod_lv_s2   <= 29'(item_s1.level) * 29'(new_weight);
			lfsr_prod_s2 <= 48'(lfsr_next) * 48'(LFSR_RECIP);
		end
		if (state_q == ST_SUM) begin
			bg_new_s3   <= bg_sum[43:16];
			lfsr_rem_s3 <= 3'(lfsr_next - 16'(lfsr_prod_s2[47:32] * 16'(NUM_GROUPS)));
		end
		if (state_q == ST_CMP) begin
			thr_s4 <= 40'(bg_new_s3) * 40'(cfg.sensitivity);
		end
	end

	always_comb begin
		bg_d           = bg_q;
		primed_d       = primed_q;
		prev_d         = prev_q;
		pulse_active_d = pulse_active_q;
		pulse_start_d  = pulse_start_q;
		last_beat_d    = last_beat_q;
		order_d        = order_q;
		stack_d        = stack_q;
		lights_d       = lights_q;
		lfsr_d         = lfsr_q;
		start_pulse    = 1'b0;
		upd_d          = 1'b0;
		beat_d         = 1'b0;
		if (!primed_q) begin
			// seed only
			bg_d        = BG_W'(item_s1.level) << 16;
			last_beat_d = item_s1.time_ms;
			primed_d    = 1'b1;
		end else begin
			bg_d   = bg_new_s3;
			prev_d = detected;
			if (trig) begin
				beat_d      = 1'b1;
				last_beat_d = item_s1.time_ms;
				case (cfg.mode)
					MODE_ALL: begin
						start_pulse = 1'b1;
						lights_d    = ALL_MASK;
						upd_d       = 1'b1;
					end
					MODE_ORDER: begin
						start_pulse = 1'b1;
						lights_d    = group_bit(3'(order_q));
						order_d     = (order_q == OC_W'(NUM_GROUPS - 1)) ? '0 : order_q + 1'b1;
						upd_d       = 1'b1;
					end
					MODE_RANDOM: begin
						start_pulse = 1'b1;
						lfsr_d      = lfsr_next;
						lights_d    = group_bit(lfsr_rem_s3);
						upd_d       = 1'b1;
					end
					MODE_STACK: begin
						if (stack_q < SC_W'(NUM_GROUPS)) begin
							lights_d = lights_q | group_bit(3'(stack_q));
						end else begin
							lights_d = lights_q & ~group_bit(3'(stack_q - SC_W'(NUM_GROUPS)));
						end
						stack_d = (stack_q == SC_W'(2 * NUM_GROUPS - 1)) ? '0 : stack_q + 1'b1;
						upd_d   = 1'b1;
					end
					default: ;
				endcase
			end
			if (start_pulse) begin
				pulse_active_d = 1'b1;
				pulse_start_d  = item_s1.time_ms;
			end else if (pulse_active_q && (since_pulse > {16'b0, cfg.pulse_ms})) begin
				pulse_active_d = 1'b0;
				lights_d       = '0;
				upd_d          = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q           <= '0;
			primed_q       <= 1'b0;
			prev_q         <= 1'b0;
			pulse_active_q <= 1'b0;
			pulse_start_q  <= '0;
			last_beat_q    <= '0;
			order_q        <= '0;
			stack_q        <= '0;
			lights_q       <= '0;
			lfsr_q         <= LFSR_SEED;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (commit) begin
				bg_q           <= bg_d;
				primed_q       <= primed_d;
				prev_q         <= prev_d;
				pulse_active_q <= pulse_active_d;
				pulse_start_q  <= pulse_start_d;
				last_beat_q    <= last_beat_d;
				order_q        <= order_d;
				stack_q        <= stack_d;
				lights_q       <= lights_d;
				lfsr_q         <= lfsr_d;
				m_tvalid_q     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {3'b0, beat_d, upd_d, lights_d[2:0]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_order_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(order_q) < NUM_GROUPS)
		else $error("order counter out of range");

	a_stack_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stack_q) < 2 * NUM_GROUPS)
		else $error("stack counter out of range");

	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("lfsr locked at zero");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> (32'(lfsr_rem_s3) < NUM_GROUPS))
		else $error("random group index out of range");

	a_beat_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && beat_d && (cfg.mode == MODE_ALL || cfg.mode == MODE_ORDER ||
			cfg.mode == MODE_RANDOM || cfg.mode == MODE_STACK)) |=> m_tdata_q[3])
		else $error("beat in a lighting mode without strip update");
`endif

endmodule

FILE: rtl/beat_detect_led_group_driver.sv
// Beat detector for an LED strip split into groups.
// Input stream: one word per microphone sample, s_tdata[11:0] sample (midscale
// 2048) and s_tdata[43:12] timestamp in ms. Output stream: one word per sample,
// m_tdata[2:0] lit groups, [3] strip update, [4] beat accepted.
// APB port: registers mode, sensitivity, smoothing, debounce_ms, pulse_ms at
// byte addresses 0x00..0x10; write them only while no sample is in flight.
// A sample goes through a small input queue into a four-step arithmetic
// sequence (background multiply, sum, threshold multiply, decide/commit).
// Each sample passes the queue, then the sequence; its word is registered at the
// output in the commit step, where the sequencer pops the next queued sample.
// The queue keeps taking input while a finished word waits at the output.
// If the receiver stalls, the output register holds its word, the sequencer
// waits in its commit step and the queue fills, then s_tready drops.
// Reset empties the queue, clears the output, loads register defaults and
// returns the detector to its unseeded state; the first sample seeds only.
module beat_detect_led_group_driver
	import bdl_pkg::*;
#(
	parameter int NUM_GROUPS = NUM_GROUPS_DEF,
	parameter int Q_DEPTH    = Q_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // sample[11:0], time_ms[43:12], zero[47:44]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // lit_groups[2:0], strip_update[3], beat_event[4]
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	bdl_cfg_t  cfg;
	bdl_item_t push_item;
	bdl_item_t pop_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	bdl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bdl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	bdl_fifo #(
		.DEPTH (Q_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (push_item),
		.pop     (q_pop),
		.rd_item (pop_item),
		.full    (q_full),
		.empty   (q_empty)
	);

	bdl_back #(
		.NUM_GROUPS (NUM_GROUPS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
